/* src/mutex_condvar_unit_core_assert.svh */
// Assertion macros for the mutex/condvar unit.
// Used by the controller and the top level; needs no package.
`ifndef MUTEX_CONDVAR_UNIT_CORE_ASSERT_SVH
`define MUTEX_CONDVAR_UNIT_CORE_ASSERT_SVH

// Assert that a condition implies something in the same cycle.
`define MCU_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");

// Assert that a condition implies something in the next cycle.
`define MCU_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* src/mcu_pkg.sv */
// Package for the mutex/condvar unit: payload structs, codes, sizes and the
// controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mcu_pkg;
  localparam int NumObjects = 32;
  localparam int NumProcs   = 16;
  localparam int IdLimit    = (NumObjects < 32) ? NumObjects : 32;
  localparam int QueueCap   = (NumProcs < 16) ? NumProcs : 16;
  localparam int ObjW       = (IdLimit > 1) ? $clog2(IdLimit) : 1;
  localparam int ProcW      = (NumProcs > 1) ? $clog2(NumProcs) : 1;
  localparam int CntW       = $clog2(QueueCap + 1);
  localparam int UseW       = $clog2(IdLimit + 1);

  typedef enum logic [2:0] {
    OP_NEW_LOCK = 3'd0, OP_NEW_CVAR = 3'd1, OP_ACQUIRE = 3'd2, OP_RELEASE = 3'd3,
    OP_WAIT = 3'd4, OP_SIGNAL = 3'd5, OP_BROADCAST = 3'd6, OP_RECLAIM = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BLOCKED = 3'd1, ST_WOKEN = 3'd2, ST_BAD_ID = 3'd3,
    ST_WRONG_TYPE = 3'd4, ST_NOT_OWNER = 3'd5, ST_FULL = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0, KIND_LOCK = 2'd1, KIND_CVAR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_BCAST, S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [4:0] object_id;
    logic [4:0] paired_lock_id;
    logic [3:0] pid;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] new_id;
    logic       woken_valid;
    logic [3:0] woken_pid;
    logic       last;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture a request
    logic exec;   // run the captured request
    logic bstep;  // pop one broadcast waiter
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic bcast;  // request continues as a broadcast walk
    logic blast;  // this pop empties the queue
  } sts_t;
endpackage
`default_nettype wire

/* src/mutex_condvar_unit_core.sv */
// Top level of the mutex/condvar unit: controller plus datapath.
// Depends on mcu_pkg, mcu_ctrl, mcu_dpath and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "mutex_condvar_unit_core_assert.svh"
// Hardware lock and condition-variable unit. One request is taken at a time:
// capture it, execute the read-modify-write of the object tables in the
// next cycle, then present the result from the output register and hold it
// until taken by out_ready. A broadcast then walks its waiter queue, one
// woken result per accepted output transaction. The next request is
// accepted once the last result of the current one is taken. The free-id
// search is a priority encoder over the kind table; no clearing pass is
// needed after reset.
module mutex_condvar_unit_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mcu_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mcu_pkg::rsp_t      out_data_o
);
  import mcu_pkg::*;
  cmd_t cmd;
  sts_t sts;

  // Sequence each transaction through capture, execute and output.
  mcu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  // Hold the tables and advance queues on the controller's commands.
  mcu_dpath u_dpath (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

  `MCU_ASSERT_IMPL(a_excl, clk_i, rst_ni, 1'b1, !(in_ready_o && out_valid_o))
  `MCU_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `MCU_ASSERT_IMPL(a_bcast_woken, clk_i, rst_ni, sts.bcast && out_valid_o,
                   out_data_o.status == ST_WOKEN)
endmodule
`default_nettype wire

/* src/mcu_ctrl.sv */
// Controller state machine of the mutex/condvar unit.
// Depends on mcu_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "mutex_condvar_unit_core_assert.svh"
module mcu_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output mcu_pkg::cmd_t     cmd_o,
  input  wire mcu_pkg::sts_t sts_i
);
  import mcu_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = sts_i.bcast ? S_BCAST : S_OUT;
      end
      S_BCAST: begin
        // hold each woken result until taken, then pop the next
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.blast) state_d = S_IDLE;
          else cmd_o.bstep = 1'b1;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  `MCU_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `MCU_ASSERT_NEXT(a_load_exec, clk_i, rst_ni, cmd_o.load, cmd_o.exec)
  `MCU_ASSERT_IMPL(a_step_out, clk_i, rst_ni, cmd_o.bstep, out_valid_o && out_ready_i)
endmodule
`default_nettype wire

/* src/mcu_dpath.sv */
// Datapath of the mutex/condvar unit: object tables, waiter links and the
// result register. Depends on mcu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcu_dpath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mcu_pkg::req_t req_i,
  input  wire mcu_pkg::cmd_t cmd_i,
  output mcu_pkg::sts_t      sts_o,
  output mcu_pkg::rsp_t      rsp_o
);
  import mcu_pkg::*;

  logic [1:0]       kind_q  [IdLimit];
  logic [IdLimit-1:0] held_q;
  logic [ProcW-1:0] owner_q [IdLimit];
  logic [ProcW-1:0] head_q  [IdLimit];
  logic [ProcW-1:0] tail_q  [IdLimit];
  logic [CntW-1:0]  cnt_q   [IdLimit];
  logic [ProcW-1:0] next_q  [NumProcs];
  logic [UseW-1:0]  use_q;

  req_t r_q;
  rsp_t rsp_q, rsp_d;
  logic bcast_q, bcast_d;

  logic idok, lkok;
  logic [ObjW-1:0] id, lk;
  logic [ProcW-1:0] pid;
  logic found;
  logic [ObjW-1:0] free_id;

  assign idok = 32'(r_q.object_id) < 32'(IdLimit);
  assign lkok = 32'(r_q.paired_lock_id) < 32'(IdLimit);
  assign id   = ObjW'(r_q.object_id);
  assign lk   = ObjW'(r_q.paired_lock_id);
  assign pid  = ProcW'(32'(r_q.pid) % NumProcs);

  // Priority encoder over the kind table for the lowest free id.
  always_comb begin
    found = 1'b0;
    free_id = '0;
    for (int i = IdLimit - 1; i >= 0; i--) begin
      if (kind_q[i] == KIND_FREE) begin
        found = 1'b1;
        free_id = ObjW'(i);
      end
    end
  end

  logic [2:0] cid, clk_st;
  always_comb begin
    if (!idok || kind_q[id] == KIND_FREE) cid = ST_BAD_ID;
    else if (kind_q[id] != ((r_q.req_type == OP_ACQUIRE || r_q.req_type == OP_RELEASE)
                            ? KIND_LOCK : KIND_CVAR)) cid = ST_WRONG_TYPE;
    else cid = ST_OK;
    if (!lkok || kind_q[lk] == KIND_FREE) clk_st = ST_BAD_ID;
    else if (kind_q[lk] != KIND_LOCK) clk_st = ST_WRONG_TYPE;
    else clk_st = ST_OK;
  end

  function automatic rsp_t mk(logic [2:0] st, logic [4:0] nid, logic v,
                              logic [ProcW-1:0] wp, logic l);
    rsp_t r;
    r.status = st;
    r.new_id = nid;
    r.woken_valid = v;
    r.woken_pid = v ? 4'(wp) : 4'd0;
    r.last = l;
    return r;
  endfunction

  logic [ProcW-1:0] bhead;
  assign bhead = head_q[id];
  assign sts_o.bcast = bcast_d;
  assign sts_o.blast = rsp_q.last;
  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < IdLimit; i++) begin
        kind_q[i] <= KIND_FREE;
        cnt_q[i] <= '0;
      end
      held_q <= '0;
      use_q <= '0;
      bcast_q <= 1'b0;
    end else begin
      bcast_q <= bcast_d;
      if (cmd_i.exec) begin
        case (r_q.req_type)
          OP_NEW_LOCK, OP_NEW_CVAR: begin
            if (found) begin
              kind_q[free_id] <= (r_q.req_type == OP_NEW_LOCK) ? KIND_LOCK : KIND_CVAR;
              held_q[free_id] <= 1'b0;
              cnt_q[free_id] <= '0;
              use_q <= use_q + UseW'(1);
            end
          end
          OP_ACQUIRE: begin
            if (cid == ST_OK) begin
              if (!held_q[id]) begin
                held_q[id] <= 1'b1;
                owner_q[id] <= pid;
              end else if (32'(cnt_q[id]) < 32'(QueueCap)) begin
                if (cnt_q[id] == '0) head_q[id] <= pid;
                else next_q[tail_q[id]] <= pid;
                tail_q[id] <= pid;
                cnt_q[id] <= cnt_q[id] + CntW'(1);
              end
            end
          end
          OP_RELEASE: begin
            if (cid == ST_OK && held_q[id] && owner_q[id] == pid) begin
              if (cnt_q[id] != '0) begin
                owner_q[id] <= head_q[id];
                head_q[id] <= next_q[head_q[id]];
                cnt_q[id] <= cnt_q[id] - CntW'(1);
              end else held_q[id] <= 1'b0;
            end
          end
          OP_WAIT: begin
            if (cid == ST_OK && clk_st == ST_OK && held_q[lk] && owner_q[lk] == pid
                && 32'(cnt_q[id]) < 32'(QueueCap)) begin
              if (cnt_q[lk] != '0) begin
                owner_q[lk] <= head_q[lk];
                head_q[lk] <= next_q[head_q[lk]];
                cnt_q[lk] <= cnt_q[lk] - CntW'(1);
              end else held_q[lk] <= 1'b0;
              // cvar and lock differ in kind, so their entries are distinct
              if (cnt_q[id] == '0) head_q[id] <= pid;
              else next_q[tail_q[id]] <= pid;
              tail_q[id] <= pid;
              cnt_q[id] <= cnt_q[id] + CntW'(1);
            end
          end
          OP_SIGNAL, OP_BROADCAST: begin
            if (cid == ST_OK && cnt_q[id] != '0) begin
              head_q[id] <= next_q[head_q[id]];
              cnt_q[id] <= cnt_q[id] - CntW'(1);
            end
          end
          OP_RECLAIM: begin
            if (idok && kind_q[id] != KIND_FREE) begin
              kind_q[id] <= KIND_FREE;
              held_q[id] <= 1'b0;
              cnt_q[id] <= '0;
              use_q <= use_q - UseW'(1);
            end
          end
          default: ;
        endcase
      end else if (cmd_i.bstep) begin
        head_q[id] <= next_q[bhead];
        cnt_q[id] <= cnt_q[id] - CntW'(1);
      end
    end
  end

  always_comb begin
    bcast_d = bcast_q;
    rsp_d = rsp_q;
    if (cmd_i.load) bcast_d = 1'b0;
    if (cmd_i.exec) begin
      bcast_d = 1'b0;
      case (r_q.req_type)
        OP_NEW_LOCK, OP_NEW_CVAR:
          rsp_d = found ? mk(ST_OK, 5'(free_id), 1'b0, '0, 1'b1)
                        : mk(ST_FULL, 5'd0, 1'b0, '0, 1'b1);
        OP_ACQUIRE: begin
          if (cid != ST_OK) rsp_d = mk(cid, 5'd0, 1'b0, '0, 1'b1);
          else if (!held_q[id]) rsp_d = mk(ST_OK, 5'd0, 1'b0, '0, 1'b1);
          else if (32'(cnt_q[id]) < 32'(QueueCap))
            rsp_d = mk(ST_BLOCKED, 5'd0, 1'b0, '0, 1'b1);
          else rsp_d = mk(ST_FULL, 5'd0, 1'b0, '0, 1'b1);
        end
        OP_RELEASE: begin
          if (cid != ST_OK) rsp_d = mk(cid, 5'd0, 1'b0, '0, 1'b1);
          else if (!held_q[id] || owner_q[id] != pid)
            rsp_d = mk(ST_NOT_OWNER, 5'd0, 1'b0, '0, 1'b1);
          else rsp_d = mk(ST_OK, 5'd0, cnt_q[id] != '0, head_q[id], 1'b1);
        end
        OP_WAIT: begin
          if (cid != ST_OK) rsp_d = mk(cid, 5'd0, 1'b0, '0, 1'b1);
          else if (clk_st != ST_OK) rsp_d = mk(clk_st, 5'd0, 1'b0, '0, 1'b1);
          else if (!held_q[lk] || owner_q[lk] != pid)
            rsp_d = mk(ST_NOT_OWNER, 5'd0, 1'b0, '0, 1'b1);
          else if (32'(cnt_q[id]) >= 32'(QueueCap))
            rsp_d = mk(ST_FULL, 5'd0, 1'b0, '0, 1'b1);
          else rsp_d = mk(ST_BLOCKED, 5'd0, cnt_q[lk] != '0, head_q[lk], 1'b1);
        end
        OP_SIGNAL, OP_BROADCAST: begin
          if (cid != ST_OK || cnt_q[id] == '0) rsp_d = mk(cid, 5'd0, 1'b0, '0, 1'b1);
          else begin
            rsp_d = mk(ST_WOKEN, 5'd0, 1'b1, head_q[id],
                       (r_q.req_type == OP_SIGNAL) || cnt_q[id] == CntW'(1));
            bcast_d = r_q.req_type == OP_BROADCAST;
          end
        end
        OP_RECLAIM:
          rsp_d = (idok && kind_q[id] != KIND_FREE) ? mk(ST_OK, 5'd0, 1'b0, '0, 1'b1)
                                                    : mk(ST_BAD_ID, 5'd0, 1'b0, '0, 1'b1);
        default: rsp_d = rsp_q;
      endcase
    end else if (cmd_i.bstep) begin
      // the head already points at the next waiter to wake
      rsp_d = mk(ST_WOKEN, 5'd0, 1'b1, bhead, cnt_q[id] == CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) r_q <= req_i;
    rsp_q <= rsp_d;
  end
endmodule
`default_nettype wire

/* tb/tb_mutex_condvar_unit_core.sv */
// Self-checking testbench for mutex_condvar_unit_core: random and directed lock and
// condvar requests, results compared against a behavioral model of the unit tables.
// Depends on mcu_pkg and the RTL of mutex_condvar_unit_core.
`timescale 1ns / 1ps
module tb_mutex_condvar_unit_core;
  import mcu_pkg::*;

  localparam int WatchLimit = 20000;
  localparam int HoldCycles = 300;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  req_t  in_data;
  logic  out_valid;
  logic  out_ready;
  rsp_t  out_data;

  mutex_condvar_unit_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Shadow copy of the object tables.
  kind_e      mdl_kind [32];
  logic       mdl_held [32];
  logic [3:0] mdl_owner[32];
  logic [3:0] mdl_head [32];
  logic [3:0] mdl_tail [32];
  int         mdl_count[32];
  logic [3:0] mdl_next [16];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int   send_idle_pct;
  int   recv_idle_pct;
  bit   recv_hold;
  int   errors;
  int   n_req_sent;
  int   n_rsp_seen;
  int   n_woken;
  int   quiet_cycles;
  int   hold_count;
  logic [4:0] id_last_lock;
  logic [4:0] id_last_cvar;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_t make_rsp(status_e st, logic [4:0] id, logic v, logic [3:0] p,
                                    logic lst);
    rsp_t r;
    r.status      = st;
    r.new_id      = id;
    r.woken_valid = v;
    r.woken_pid   = v ? p : 4'd0;
    r.last        = lst;
    return r;
  endfunction

  function automatic status_e kind_check(logic [4:0] id, kind_e k);
    if (mdl_kind[id] == KIND_FREE) return ST_BAD_ID;
    if (mdl_kind[id] != k) return ST_WRONG_TYPE;
    return ST_OK;
  endfunction

  function automatic void push_waiter(logic [4:0] q, logic [3:0] p);
    if (mdl_count[q] == 0) mdl_head[q] = p;
    else mdl_next[mdl_tail[q]] = p;
    mdl_tail[q] = p;
    mdl_count[q]++;
  endfunction

  function automatic logic [3:0] pop_waiter(logic [4:0] q);
    logic [3:0] p;
    p = mdl_head[q];
    mdl_head[q] = mdl_next[p];
    mdl_count[q]--;
    return p;
  endfunction

  // Hand the lock to the head waiter or free it; returns 1 on hand-off.
  function automatic logic drop_lock(logic [4:0] l, output logic [3:0] nxt);
    nxt = 4'd0;
    if (mdl_count[l] != 0) begin
      nxt = pop_waiter(l);
      mdl_owner[l] = nxt;
      return 1'b1;
    end
    mdl_held[l] = 1'b0;
    return 1'b0;
  endfunction

  // Update the shadow tables for one request and queue its results.
  function automatic void predict_request(req_t rq);
    status_e    st;
    logic [3:0] nxt;
    logic       v;
    logic [4:0] id;
    logic [4:0] lk;
    bit         found;
    id  = rq.object_id;
    lk  = rq.paired_lock_id;
    nxt = 4'd0;
    v   = 1'b0;
    found = 1'b0;
    case (op_e'(rq.req_type))
      OP_NEW_LOCK, OP_NEW_CVAR: begin
        for (int i = 0; i < 32; i++) begin
          if (!found && mdl_kind[i] == KIND_FREE) begin
            found = 1'b1;
            mdl_kind[i]  = (rq.req_type == OP_NEW_LOCK) ? KIND_LOCK : KIND_CVAR;
            mdl_held[i]  = 1'b0;
            mdl_count[i] = 0;
            expected_rsps.push_back(make_rsp(ST_OK, 5'(i), 1'b0, 4'd0, 1'b1));
          end
        end
        if (!found) expected_rsps.push_back(make_rsp(ST_FULL, 5'd0, 1'b0, 4'd0, 1'b1));
      end
      OP_ACQUIRE: begin
        st = kind_check(id, KIND_LOCK);
        if (st == ST_OK) begin
          if (!mdl_held[id]) begin
            mdl_held[id]  = 1'b1;
            mdl_owner[id] = rq.pid;
          end else if (mdl_count[id] >= QueueCap) begin
            st = ST_FULL;
          end else begin
            push_waiter(id, rq.pid);
            st = ST_BLOCKED;
          end
        end
        expected_rsps.push_back(make_rsp(st, 5'd0, 1'b0, 4'd0, 1'b1));
      end
      OP_RELEASE: begin
        st = kind_check(id, KIND_LOCK);
        if (st == ST_OK) begin
          if (!mdl_held[id] || mdl_owner[id] != rq.pid) st = ST_NOT_OWNER;
          else v = drop_lock(id, nxt);
        end
        expected_rsps.push_back(make_rsp(st, 5'd0, v, nxt, 1'b1));
      end
      OP_WAIT: begin
        st = kind_check(id, KIND_CVAR);
        if (st == ST_OK) st = kind_check(lk, KIND_LOCK);
        if (st == ST_OK && (!mdl_held[lk] || mdl_owner[lk] != rq.pid)) st = ST_NOT_OWNER;
        if (st == ST_OK && mdl_count[id] >= QueueCap) st = ST_FULL;
        if (st == ST_OK) begin
          v = drop_lock(lk, nxt);
          push_waiter(id, rq.pid);
          st = ST_BLOCKED;
        end
        expected_rsps.push_back(make_rsp(st, 5'd0, v, nxt, 1'b1));
      end
      OP_SIGNAL: begin
        st = kind_check(id, KIND_CVAR);
        if (st == ST_OK && mdl_count[id] != 0) begin
          nxt = pop_waiter(id);
          n_woken++;
          expected_rsps.push_back(make_rsp(ST_WOKEN, 5'd0, 1'b1, nxt, 1'b1));
        end else begin
          expected_rsps.push_back(make_rsp(st, 5'd0, 1'b0, 4'd0, 1'b1));
        end
      end
      OP_BROADCAST: begin
        st = kind_check(id, KIND_CVAR);
        if (st != ST_OK || mdl_count[id] == 0) begin
          expected_rsps.push_back(make_rsp(st, 5'd0, 1'b0, 4'd0, 1'b1));
        end else begin
          while (mdl_count[id] != 0) begin
            nxt = pop_waiter(id);
            n_woken++;
            expected_rsps.push_back(make_rsp(ST_WOKEN, 5'd0, 1'b1, nxt, mdl_count[id] == 0));
          end
        end
      end
      default: begin
        if (mdl_kind[id] == KIND_FREE) begin
          expected_rsps.push_back(make_rsp(ST_BAD_ID, 5'd0, 1'b0, 4'd0, 1'b1));
        end else begin
          mdl_kind[id]  = KIND_FREE;
          mdl_held[id]  = 1'b0;
          mdl_count[id] = 0;
          expected_rsps.push_back(make_rsp(ST_OK, 5'd0, 1'b0, 4'd0, 1'b1));
        end
      end
    endcase
  endfunction

  function automatic req_t mk_req(op_e op, int id, int lk, int p);
    req_t r;
    r.req_type       = op;
    r.object_id      = 5'(id);
    r.paired_lock_id = 5'(lk);
    r.pid            = 4'(p);
    return r;
  endfunction

  // Driver: present the next pending transaction, hold it until accepted.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_request(in_data);
        n_req_sent++;
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result and pick the next ready value.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_rsp_seen++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_data);
          errors++;
        end else begin
          rsp_t exp_r;
          exp_r = expected_rsps.pop_front();
          if (exp_r !== out_data) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, out_data);
            errors++;
          end
        end
      end
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run after a long stretch with no transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchLimit) begin
        $display("watchdog expired");
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Random request biased toward live objects and a few process ids.
  function automatic req_t rand_req();
    int r;
    int id;
    int p;
    r  = $urandom_range(99);
    p  = (r < 90) ? $urandom_range(3) : $urandom_range(15);
    id = ($urandom_range(9) < 7) ? $urandom_range(7) : $urandom_range(31);
    if (r < 6) return mk_req(OP_NEW_LOCK, $urandom_range(31), $urandom_range(31), p);
    if (r < 12) return mk_req(OP_NEW_CVAR, $urandom_range(31), $urandom_range(31), p);
    if (r < 32) return mk_req(OP_ACQUIRE, id, $urandom_range(31), p);
    if (r < 50) return mk_req(OP_RELEASE, id, $urandom_range(31), p);
    if (r < 66) return mk_req(OP_WAIT, id, $urandom_range(7), p);
    if (r < 78) return mk_req(OP_SIGNAL, id, $urandom_range(31), p);
    if (r < 90) return mk_req(OP_BROADCAST, id, $urandom_range(31), p);
    return mk_req(OP_RECLAIM, id, $urandom_range(31), p);
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 32; i++) begin
      mdl_kind[i]  = KIND_FREE;
      mdl_held[i]  = 1'b0;
      mdl_owner[i] = '0;
      mdl_head[i]  = '0;
      mdl_tail[i]  = '0;
      mdl_count[i] = 0;
    end
    for (int i = 0; i < 16; i++) mdl_next[i] = '0;
    errors = 0; n_req_sent = 0; n_rsp_seen = 0; n_woken = 0;
    quiet_cycles = 0; recv_hold = 1'b0;
    send_idle_pct = 37; recv_idle_pct = 68;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: errors on free ids, create, contention, wait/signal/broadcast.
    pending_reqs.push_back(mk_req(OP_ACQUIRE, 31, 0, 0));
    pending_reqs.push_back(mk_req(OP_RECLAIM, 0, 31, 15));
    pending_reqs.push_back(mk_req(OP_NEW_LOCK, 0, 0, 0));      // id 0
    pending_reqs.push_back(mk_req(OP_NEW_CVAR, 31, 31, 15));   // id 1
    pending_reqs.push_back(mk_req(OP_SIGNAL, 0, 0, 0));        // wrong type
    pending_reqs.push_back(mk_req(OP_ACQUIRE, 1, 0, 0));       // wrong type
    pending_reqs.push_back(mk_req(OP_BROADCAST, 1, 0, 0));     // empty
    pending_reqs.push_back(mk_req(OP_SIGNAL, 1, 0, 0));        // empty
    pending_reqs.push_back(mk_req(OP_RELEASE, 0, 0, 3));       // not held
    pending_reqs.push_back(mk_req(OP_ACQUIRE, 0, 0, 15));
    pending_reqs.push_back(mk_req(OP_ACQUIRE, 0, 0, 15));      // owner queues behind itself
    pending_reqs.push_back(mk_req(OP_ACQUIRE, 0, 0, 5));
    pending_reqs.push_back(mk_req(OP_RELEASE, 0, 0, 5));       // not owner
    pending_reqs.push_back(mk_req(OP_WAIT, 1, 1, 15));         // paired lock wrong type
    pending_reqs.push_back(mk_req(OP_WAIT, 1, 0, 15));         // hands lock to 15
    pending_reqs.push_back(mk_req(OP_WAIT, 1, 0, 15));         // hands lock to 5
    pending_reqs.push_back(mk_req(OP_WAIT, 1, 0, 5));
    pending_reqs.push_back(mk_req(OP_SIGNAL, 1, 0, 0));
    pending_reqs.push_back(mk_req(OP_BROADCAST, 1, 0, 0));
    pending_reqs.push_back(mk_req(OP_RECLAIM, 1, 0, 0));
    pending_reqs.push_back(mk_req(OP_WAIT, 1, 0, 0));          // freed cvar
    for (int i = 0; i < 32; i++) pending_reqs.push_back(mk_req(OP_NEW_CVAR, 0, 0, 0));
    pending_reqs.push_back(mk_req(OP_NEW_LOCK, 0, 0, 0));      // table full
    for (int i = 0; i < 32; i++) pending_reqs.push_back(mk_req(OP_RECLAIM, i, 0, 0));
    drain();

    // Queue overflow: sixteen waiters on a lock, then one more.
    pending_reqs.push_back(mk_req(OP_NEW_LOCK, 0, 0, 0));
    for (int i = 0; i < 18; i++) pending_reqs.push_back(mk_req(OP_ACQUIRE, 0, 0, i));
    // Receiver holds off so the unit backs up its input.
    recv_hold = 1'b1;
    hold_count = 0;
    while (hold_count < HoldCycles) begin
      @(posedge clk);
      hold_count++;
    end
    recv_hold = 1'b0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 68; recv_idle_pct = 37; end
      if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      for (int i = 0; i < 2; i++) begin
        pending_reqs.push_back(mk_req(OP_NEW_LOCK, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_NEW_CVAR, 0, 0, 0));
      end
      for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req());
      drain();
    end

    $display("Ran %0d requests, checked %0d results, %0d processes woken from condvars.",
             n_req_sent, n_rsp_seen, n_woken);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
